// ===== rtl/md5_pkg.sv =====
`default_nettype none

package md5_pkg;

  // Initial chaining values.
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Padding marker byte.
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Additive constant for each of the 64 rounds.
  localparam logic [31:0] ROUND_CONST [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_byte;  // store the incoming byte and count it
    logic start;       // load working words from the chaining words
    logic round_en;    // run one compression round
    logic add;         // fold working words into the chaining words
    logic pad;         // pad the block after the last byte
    logic zero;        // clear the block and write only the length
    logic clear_msg;   // restart for a new message
  } md5_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_last;    // next byte completes a block
    logic pos_ge56;    // no room left for the length in this block
    logic round_last;  // round 63 is running
  } md5_sts_t;

  // Message word used by a round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] g;
    r = rnd[3:0];
    unique case (rnd[5:4])
      2'd0: g = r;
      2'd1: g = 4'(r * 4'd5 + 4'd1);
      2'd2: g = 4'(r * 4'd3 + 4'd5);
      default: g = 4'(r * 4'd7);
    endcase
    return g;
  endfunction

  // Left rotate amount of a round.
  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    logic [4:0] s;
    unique case ({rnd[5:4], rnd[1:0]})
      4'd0:  s = 5'd7;
      4'd1:  s = 5'd12;
      4'd2:  s = 5'd17;
      4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;
      4'd5:  s = 5'd9;
      4'd6:  s = 5'd14;
      4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;
      4'd9:  s = 5'd11;
      4'd10: s = 5'd16;
      4'd11: s = 5'd23;
      4'd12: s = 5'd6;
      4'd13: s = 5'd10;
      4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // 32-bit left rotate.
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/md5_datapath.sv =====
`default_nettype none

module md5_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire md5_pkg::md5_cmd_t cmd_i,
  input  wire logic [7:0]      message_byte_i,
  input  wire logic [1:0]      out_idx_i,
  output md5_pkg::md5_sts_t    sts_o,
  output logic [31:0]          digest_word_o
);

  logic [31:0] blk_q   [16];
  logic [31:0] blk_d   [16];
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] work_q  [4];
  logic [31:0] work_d  [4];
  logic [60:0] len_q, len_d;
  logic [5:0]  round_q, round_d;

  logic [3:0]  pos_word;
  logic [1:0]  pos_lane;
  logic [31:0] bits_lo, bits_hi;
  logic [31:0] func_f, round_sum, round_rot;

  assign pos_word = len_q[5:2];
  assign pos_lane = len_q[1:0];
  // Bit count of the message, modulo 2^64.
  assign bits_lo  = {len_q[28:0], 3'b000};
  assign bits_hi  = len_q[60:29];

  assign sts_o.pos_last   = &len_q[5:0];
  assign sts_o.pos_ge56   = &len_q[5:3];
  assign sts_o.round_last = &round_q;

  assign digest_word_o = chain_q[out_idx_i];

  // Round function and the sum that feeds the rotate.
  always_comb begin
    unique case (round_q[5:4])
      2'd0: func_f = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      2'd1: func_f = (work_q[1] & work_q[3]) | (work_q[2] & ~work_q[3]);
      2'd2: func_f = work_q[1] ^ work_q[2] ^ work_q[3];
      default: func_f = work_q[2] ^ (work_q[1] | ~work_q[3]);
    endcase
    round_sum = func_f + work_q[0] + md5_pkg::ROUND_CONST[round_q]
              + blk_q[md5_pkg::msg_index(round_q)];
    round_rot = md5_pkg::rotl32(round_sum, md5_pkg::rot_amount(round_q));
  end

  // Block words: byte insertion, padding and the length words.
  always_comb begin
    for (int w = 0; w < 16; w++) begin
      blk_d[w] = blk_q[w];
      if (cmd_i.write_byte && (4'(w) == pos_word)) begin
        for (int j = 0; j < 4; j++) begin
          if (2'(j) == pos_lane) begin
            blk_d[w][8*j +: 8] = message_byte_i;
          end
        end
      end
      if (cmd_i.pad) begin
        if (4'(w) > pos_word) begin
          blk_d[w] = '0;
        end else if (4'(w) == pos_word) begin
          for (int j = 0; j < 4; j++) begin
            if (2'(j) == pos_lane) begin
              blk_d[w][8*j +: 8] = md5_pkg::PAD_BYTE;
            end else if (2'(j) > pos_lane) begin
              blk_d[w][8*j +: 8] = 8'h00;
            end
          end
        end
      end
      if (cmd_i.zero) begin
        blk_d[w] = '0;
      end
    end
    // The length goes in now unless it has to wait for an extra block.
    if (cmd_i.zero || (cmd_i.pad && !sts_o.pos_ge56)) begin
      blk_d[14] = bits_lo;
      blk_d[15] = bits_hi;
    end
  end

  // Working words, round counter, chaining words and length.
  always_comb begin
    work_d  = work_q;
    chain_d = chain_q;
    round_d = round_q;
    len_d   = len_q;
    if (cmd_i.start) begin
      work_d  = chain_q;
      round_d = '0;
    end
    if (cmd_i.round_en) begin
      work_d[0] = work_q[3];
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[1] + round_rot;
      round_d   = round_q + 6'd1;
    end
    if (cmd_i.add) begin
      for (int k = 0; k < 4; k++) begin
        chain_d[k] = chain_q[k] + work_q[k];
      end
    end
    if (cmd_i.write_byte) begin
      len_d = len_q + 61'd1;
    end
    if (cmd_i.clear_msg) begin
      chain_d = '{md5_pkg::IV_A, md5_pkg::IV_B, md5_pkg::IV_C, md5_pkg::IV_D};
      len_d   = '0;
    end
  end

  // Control state of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '{md5_pkg::IV_A, md5_pkg::IV_B, md5_pkg::IV_C, md5_pkg::IV_D};
      len_q   <= '0;
      round_q <= '0;
    end else begin
      chain_q <= chain_d;
      len_q   <= len_d;
      round_q <= round_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    blk_q  <= blk_d;
    work_q <= work_d;
  end

endmodule

`default_nettype wire

// ===== rtl/md5_ctrl.sv =====
`default_nettype none

module md5_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic            byte_valid_i,
  input  wire logic            last_byte_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [1:0]           out_idx_o,
  output logic                 last_word_o,
  input  wire md5_pkg::md5_sts_t sts_i,
  output md5_pkg::md5_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_PAD  = 3'd3;
  localparam logic [2:0] S_ZERO = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       last_pend_q, last_pend_d;
  logic       final_q, final_d;
  logic       len_blk_q, len_blk_d;
  logic [1:0] idx_q, idx_d;
  logic       in_acc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_idx_o   = idx_q;
  assign last_word_o = (idx_q == 2'd3);
  assign in_acc      = in_valid_i && !in_stall_o;

  // Sequencing of byte intake, compression, padding and digest beats.
  always_comb begin
    state_d     = state_q;
    last_pend_d = last_pend_q;
    final_d     = final_q;
    len_blk_d   = len_blk_q;
    idx_d       = idx_q;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.write_byte = in_acc && byte_valid_i;
        if (in_acc) begin
          if (byte_valid_i && sts_i.pos_last) begin
            cmd_o.start = 1'b1;
            last_pend_d = last_byte_i;
            final_d     = 1'b0;
            state_d     = S_COMP;
          end else if (last_byte_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_COMP: begin
        cmd_o.round_en = 1'b1;
        if (sts_i.round_last) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        priority if (final_q) begin
          idx_d   = 2'd0;
          state_d = S_OUT;
        end else if (last_pend_q) begin
          last_pend_d = 1'b0;
          state_d     = S_PAD;
        end else if (len_blk_q) begin
          state_d = S_ZERO;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PAD: begin
        cmd_o.pad   = 1'b1;
        cmd_o.start = 1'b1;
        len_blk_d   = sts_i.pos_ge56;
        final_d     = !sts_i.pos_ge56;
        state_d     = S_COMP;
      end
      S_ZERO: begin
        cmd_o.zero  = 1'b1;
        cmd_o.start = 1'b1;
        len_blk_d   = 1'b0;
        final_d     = 1'b1;
        state_d     = S_COMP;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            cmd_o.clear_msg = 1'b1;
            final_d         = 1'b0;
            state_d         = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_pend_q <= 1'b0;
      final_q     <= 1'b0;
      len_blk_q   <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      state_q     <= state_d;
      last_pend_q <= last_pend_d;
      final_q     <= final_d;
      len_blk_q   <= len_blk_d;
      idx_q       <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/md5_message_digest_top.sv =====
// MD5 digest over a byte stream. One beat carries one message byte (or none,
// with byte_valid low, to close a message) and a last flag. Bytes are taken
// one per cycle while a 64-byte block fills. The beat that completes a block
// holds the input off while 64 rounds run through the single round unit,
// one round per cycle, and the result is then folded into the chaining
// words. A last beat adds one padding step and a further compression, or
// two of each when the 0x80 marker leaves fewer than 8 bytes in the block
// for the length.
// The four digest words a, b, c, d then leave as four output beats, held
// while out_stall_i is high, and the block is ready for the next message.
`default_nettype none

module md5_message_digest_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  message_byte_i,
  input  wire logic        byte_valid_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      digest_word_o,
  output logic [1:0]       word_index_o,
  output logic             last_word_o
);

  md5_pkg::md5_cmd_t cmd;
  md5_pkg::md5_sts_t sts;
  logic [1:0]        out_idx;

  assign word_index_o = out_idx;

  md5_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_valid_i (byte_valid_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_idx_o    (out_idx),
    .last_word_o  (last_word_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  md5_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .message_byte_i (message_byte_i),
    .out_idx_i      (out_idx),
    .sts_o          (sts),
    .digest_word_o  (digest_word_o)
  );

  // No input is taken while digest beats are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted during digest output");

  // The final digest beat ends the output burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_word_o) |=> !out_valid_o)
    else $error("output continued past the last digest word");

  // The last round is always followed by the chaining update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.round_en && sts.round_last) |=> cmd.add)
    else $error("chaining update missing after round 63");

  // Bytes are never written into a block under compression.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.round_en |-> !cmd.write_byte && !cmd.pad && !cmd.zero)
    else $error("block words changed during compression");

endmodule

`default_nettype wire
